### rtl/core/jvs_pkg.sv
// joystick velocity shaping: shared constants, config register codes, types
// and the restoring divider step used by the divider pipelines
// no dependencies
`timescale 1ns / 1ps
package jvs_pkg;

  localparam int FULL_SCALE = 32767;
  localparam int AXIS_W     = 16;
  localparam int MAG_W      = 15;
  localparam int NUM_AXES   = 3;
  localparam int LANES      = 3;
  localparam int DIV_STEPS  = MAG_W;
  localparam int DEN_W      = 32;
  localparam int TAG_W      = 20;
  localparam int IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    CFG_FWD_MAX  = 3'd0,
    CFG_TURN_MAX = 3'd1,
    CFG_FWD_DZ   = 3'd2,
    CFG_TURN_DZ  = 3'd3,
    CFG_STR_DZ   = 3'd4,
    CFG_REV_MASK = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [MAG_W-1:0]    fwd_max;
    logic [MAG_W-1:0]    turn_max;
    logic [MAG_W-1:0]    fwd_dz;
    logic [MAG_W-1:0]    turn_dz;
    logic [MAG_W-1:0]    str_dz;
    logic [NUM_AXES-1:0] rev_mask;
  } cfg_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [MAG_W-1:0] low;
    logic [DEN_W-1:0] den;
    logic [MAG_W-1:0] quo;
  } div_lane_t;

  // one quotient bit; rem stays below den
  function automatic div_lane_t div_step(div_lane_t l);
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           qbit;
    div_lane_t      r;
    t    = {l.rem, l.low[MAG_W-1]};
    diff = t - {1'b0, l.den};
    qbit = (t >= {1'b0, l.den});
    r     = l;
    r.rem = qbit ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    r.low = {l.low[MAG_W-2:0], 1'b0};
    r.quo = {l.quo[MAG_W-2:0], qbit};
    return r;
  endfunction

endpackage

### rtl/core/jvs_cfg_regs.sv
// configuration register bank for joystick velocity shaping
// depends on jvs_pkg
`timescale 1ns / 1ps
module jvs_cfg_regs import jvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [MAG_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FWD_MAX:  cfg_d.fwd_max  = cfg_data_i;
        CFG_TURN_MAX: cfg_d.turn_max = cfg_data_i;
        CFG_FWD_DZ:   cfg_d.fwd_dz   = cfg_data_i;
        CFG_TURN_DZ:  cfg_d.turn_dz  = cfg_data_i;
        CFG_STR_DZ:   cfg_d.str_dz   = cfg_data_i;
        CFG_REV_MASK: cfg_d.rev_mask = cfg_data_i[NUM_AXES-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fwd_max  <= MAG_W'(32767);
      cfg_q.turn_max <= MAG_W'(6553);
      cfg_q.fwd_dz   <= MAG_W'(983);
      cfg_q.turn_dz  <= MAG_W'(983);
      cfg_q.str_dz   <= MAG_W'(1311);
      cfg_q.rev_mask <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/jvs_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, LANES lanes
// plus a sideband tag; depends on jvs_pkg
`timescale 1ns / 1ps
module jvs_div_pipe import jvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  div_lane_t        lane_i [LANES],
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [MAG_W-1:0] quo_o [LANES],
  output logic [TAG_W-1:0] tag_o
);

  div_lane_t          lane_q [DIV_STEPS][LANES];
  logic [TAG_W-1:0]   tag_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int l = 0; l < LANES; l++) lane_q[0][l] <= div_step(lane_i[l]);
      for (int k = 1; k < DIV_STEPS; k++) begin
        tag_q[k] <= tag_q[k-1];
        for (int l = 0; l < LANES; l++) lane_q[k][l] <= div_step(lane_q[k-1][l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) quo_o[l] = lane_q[DIV_STEPS-1][l].quo;
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign tag_o   = tag_q[DIV_STEPS-1];

endmodule

### rtl/core/joystick_velocity_shaping.sv
// Joystick velocity shaping: a sample of three axes is mapped through dead
// zone and linear scaling, the forward/turn pair is held inside the speed
// diamond and a live straight axis overrides the command. One sample enters
// per clock unless halted: the whole pipeline halts while a finished beat
// waits at the output. Stages: input map, a 15-stage divider for the axis
// scaling, axis magnitudes, diamond products, a second 15-stage divider for
// the pull-back onto the diamond edge, and the output register. Config must
// be written only while the pipeline is empty; the block does not enforce
// this. Depends on jvs_pkg, jvs_cfg_regs and jvs_div_pipe.
`timescale 1ns / 1ps
module joystick_velocity_shaping import jvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // forward_axis [15:0], turn_axis [31:16], straight_axis [47:32]
  input  logic [47:0]      s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // speed_forward [15:0], speed_turn [31:16]
  output logic [31:0]      m_axis_tdata_o,
  // was_limited [0], straight_override [1]
  output logic [1:0]       m_axis_tuser_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [MAG_W-1:0] cfg_data_i
);

  localparam logic [MAG_W-1:0] FS = MAG_W'(FULL_SCALE);

  cfg_t cfg;
  logic en;

  jvs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [MAG_W-1:0] dead [NUM_AXES];
  logic [MAG_W-1:0] omax [NUM_AXES];
  assign dead[0] = cfg.fwd_dz;
  assign dead[1] = cfg.turn_dz;
  assign dead[2] = cfg.str_dz;
  assign omax[0] = cfg.fwd_max;
  assign omax[1] = cfg.turn_max;
  assign omax[2] = cfg.fwd_max;

  // ---------------- stage a: negate, clamp, dead zone
  logic [MAG_W-1:0]    fe_diff [NUM_AXES];
  logic [NUM_AXES-1:0] fe_sgn, fe_zero, fe_full;

  always_comb begin
    logic signed [AXIS_W:0] x;
    logic [AXIS_W:0]        nx;
    logic [MAG_W-1:0]       mag;
    for (int i = 0; i < NUM_AXES; i++) begin
      x = {s_axis_tdata_i[AXIS_W*i+AXIS_W-1], s_axis_tdata_i[AXIS_W*i +: AXIS_W]};
      if (cfg.rev_mask[i]) x = -x;
      if (x > $signed({2'b00, FS})) x = $signed({2'b00, FS});
      if (x < -$signed({2'b00, FS})) x = -$signed({2'b00, FS});
      nx         = -x;
      fe_sgn[i]  = x[AXIS_W];
      mag        = x[AXIS_W] ? nx[MAG_W-1:0] : x[MAG_W-1:0];
      fe_zero[i] = (mag < dead[i]);
      fe_full[i] = (dead[i] == FS);
      fe_diff[i] = mag - dead[i];
    end
  end

  logic                a_vld_q;
  logic [MAG_W-1:0]    a_diff_q [NUM_AXES];
  logic [NUM_AXES-1:0] a_sgn_q, a_zero_q, a_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_diff_q <= fe_diff;
      a_sgn_q  <= fe_sgn;
      a_zero_q <= fe_zero;
      a_full_q <= fe_full;
    end
  end

  // ---------------- axis scaling divider: omax*(mag-dead) / (FS-dead)
  div_lane_t        d1_lane [LANES];
  logic [TAG_W-1:0] d1_tag;

  always_comb begin
    logic [2*MAG_W-1:0] num;
    for (int i = 0; i < LANES; i++) begin
      num            = omax[i] * a_diff_q[i];
      d1_lane[i].rem = DEN_W'(num[2*MAG_W-1:MAG_W]);
      d1_lane[i].low = num[MAG_W-1:0];
      d1_lane[i].den = DEN_W'(FS - dead[i]);
      d1_lane[i].quo = '0;
    end
    d1_tag = TAG_W'({a_sgn_q, a_zero_q, a_full_q});
  end

  logic             p1_vld;
  logic [MAG_W-1:0] p1_quo [LANES];
  logic [TAG_W-1:0] p1_tag;

  jvs_div_pipe u_axis_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_vld_q),
    .lane_i  (d1_lane),
    .tag_i   (d1_tag),
    .valid_o (p1_vld),
    .quo_o   (p1_quo),
    .tag_o   (p1_tag)
  );

  // ---------------- stage c: axis magnitudes
  logic [NUM_AXES-1:0] p1_sgn, p1_zero, p1_full;
  logic [MAG_W-1:0]    p1_mag [NUM_AXES];
  assign {p1_sgn, p1_zero, p1_full} = p1_tag[3*NUM_AXES-1:0];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      p1_mag[i] = p1_zero[i] ? '0 : (p1_full[i] ? omax[i] : p1_quo[i]);
    end
  end

  logic                c_vld_q;
  logic [MAG_W-1:0]    c_mag_q [NUM_AXES];
  logic [NUM_AXES-1:0] c_sgn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= p1_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_mag_q <= p1_mag;
      c_sgn_q <= p1_sgn;
    end
  end

  // ---------------- stage d: diamond products
  logic [DEN_W-1:0]   c_sum;
  logic [2*MAG_W-1:0] c_prod;
  logic [AXIS_W-1:0]  c_str;
  assign c_sum  = DEN_W'(c_mag_q[0]) * DEN_W'(cfg.turn_max)
                + DEN_W'(c_mag_q[1]) * DEN_W'(cfg.fwd_max);
  assign c_prod = cfg.fwd_max * cfg.turn_max;
  assign c_str  = c_sgn_q[2] ? -{1'b0, c_mag_q[2]} : {1'b0, c_mag_q[2]};

  logic               d_vld_q;
  logic [DEN_W-1:0]   d_sum_q;
  logic [2*MAG_W-1:0] d_prod_q;
  logic [MAG_W-1:0]   d_av_q, d_aw_q;
  logic [1:0]         d_sgn_q;
  logic [AXIS_W-1:0]  d_str_q;
  logic               d_ovr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= c_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sum_q  <= c_sum;
      d_prod_q <= c_prod;
      d_av_q   <= c_mag_q[0];
      d_aw_q   <= c_mag_q[1];
      d_sgn_q  <= c_sgn_q[1:0];
      d_str_q  <= c_str;
      d_ovr_q  <= (c_mag_q[2] != '0);
    end
  end

  // ---------------- diamond pull-back divider: prod*|x| / sum
  // an unlimited pair goes through as x*2^15 / 2^15
  logic             d_lim;
  div_lane_t        d2_lane [LANES];
  logic [TAG_W-1:0] d2_tag;

  assign d_lim = (d_av_q != '0) && (d_aw_q != '0) && (d_sum_q > DEN_W'(d_prod_q));

  always_comb begin
    logic [3*MAG_W-1:0] dv;
    logic [MAG_W-1:0]   ax;
    for (int l = 0; l < 2; l++) begin
      ax = (l == 0) ? d_av_q : d_aw_q;
      dv = d_prod_q * ax;
      if (d_lim) begin
        d2_lane[l].rem = DEN_W'(dv[3*MAG_W-1:MAG_W]);
        d2_lane[l].low = dv[MAG_W-1:0];
        d2_lane[l].den = d_sum_q;
      end else begin
        d2_lane[l].rem = DEN_W'(ax);
        d2_lane[l].low = '0;
        d2_lane[l].den = DEN_W'(33'd1 << MAG_W);
      end
      d2_lane[l].quo = '0;
    end
    d2_lane[2].rem = '0;
    d2_lane[2].low = '0;
    d2_lane[2].den = DEN_W'(1);
    d2_lane[2].quo = '0;
    d2_tag = {d_ovr_q, d_lim, d_sgn_q, d_str_q};
  end

  logic             p2_vld;
  logic [MAG_W-1:0] p2_quo [LANES];
  logic [TAG_W-1:0] p2_tag;

  jvs_div_pipe u_diamond_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld_q),
    .lane_i  (d2_lane),
    .tag_i   (d2_tag),
    .valid_o (p2_vld),
    .quo_o   (p2_quo),
    .tag_o   (p2_tag)
  );

  // ---------------- output register
  logic              p2_ovr, p2_lim;
  logic [1:0]        p2_sgn;
  logic [AXIS_W-1:0] p2_str, p2_v, p2_w;
  assign {p2_ovr, p2_lim, p2_sgn, p2_str} = p2_tag;
  assign p2_v = p2_sgn[0] ? -{1'b0, p2_quo[0]} : {1'b0, p2_quo[0]};
  assign p2_w = p2_sgn[1] ? -{1'b0, p2_quo[1]} : {1'b0, p2_quo[1]};

  logic        out_vld_q;
  logic [31:0] out_data_q;
  logic [1:0]  out_user_q;

  assign en = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= p2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= p2_ovr ? {16'h0000, p2_str} : {p2_w, p2_v};
      out_user_q <= {p2_ovr, p2_lim && !p2_ovr};
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // ---------------- checks
  logic [AXIS_W-1:0] out_turn_mag;
  assign out_turn_mag = out_data_q[31] ? -out_data_q[31:16] : out_data_q[31:16];

  a_ovr_turn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o[31:16] == '0))
    else $error("override beat with nonzero turn");

  a_ovr_not_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[1] && m_axis_tuser_o[0]))
    else $error("override and limited both set");

  a_turn_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_turn_mag <= AXIS_W'(cfg.turn_max)))
    else $error("turn exceeds turn_max");

endmodule

### sim/tb_top.sv
// testbench for joystick_velocity_shaping: random and directed axis samples,
// predicted commands checked beat by beat against the output stream
// depends on jvs_pkg and the joystick_velocity_shaping rtl
`timescale 1ns / 1ps
module tb_top;
  import jvs_pkg::*;

  localparam int LATENCY   = 34;
  localparam int MAX_CYCLE = 1000000;

  typedef struct packed {
    logic signed [15:0] straight;
    logic signed [15:0] turn;
    logic signed [15:0] fwd;
  } sample_t;

  typedef struct {
    logic signed [15:0] spd_fwd;
    logic signed [15:0] spd_turn;
    logic               limited;
    logic               override;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [MAG_W-1:0] cfg_data_i = '0;

  joystick_velocity_shaping dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the config registers
  int unsigned fwd_max_q, turn_max_q, fwd_dz_q, turn_dz_q, str_dz_q, rev_q;

  sample_t  pending_q[$];
  command_t expected_q[$];
  int       errors = 0;
  int       cycle = 0;
  bit       tx_idle_en = 1'b1;
  bit       rx_idle_en = 1'b1;
  int       rx_hold = 0;

  function automatic int map_axis(logic signed [15:0] raw, bit neg,
                                  int unsigned dz, int unsigned omax);
    int v;
    int unsigned m;
    longint unsigned o;
    v = raw;
    if (neg) v = -v;
    if (v > FULL_SCALE) v = FULL_SCALE;
    if (v < -FULL_SCALE) v = -FULL_SCALE;
    m = (v < 0) ? -v : v;
    if (m < dz) return 0;
    if (dz >= FULL_SCALE) o = omax;
    else o = (longint'(omax) * (m - dz)) / (FULL_SCALE - dz);
    return (v < 0) ? -int'(o) : int'(o);
  endfunction

  function automatic command_t shape_command(sample_t s);
    command_t c;
    int v, w, st;
    longint unsigned av, aw, sum, prod;
    v  = map_axis(s.fwd, rev_q[0], fwd_dz_q, fwd_max_q);
    w  = map_axis(s.turn, rev_q[1], turn_dz_q, turn_max_q);
    st = map_axis(s.straight, rev_q[2], str_dz_q, fwd_max_q);
    c.limited = 1'b0;
    if (v != 0 && w != 0) begin
      av = (v < 0) ? -v : v;
      aw = (w < 0) ? -w : w;
      sum = av * turn_max_q + aw * fwd_max_q;
      prod = longint'(fwd_max_q) * turn_max_q;
      if (sum > prod) begin
        v = (v < 0) ? -int'(prod * av / sum) : int'(prod * av / sum);
        w = (w < 0) ? -int'(prod * aw / sum) : int'(prod * aw / sum);
        c.limited = 1'b1;
      end
    end
    if (st != 0) begin
      c.spd_fwd = 16'(st); c.spd_turn = '0; c.limited = 1'b0; c.override = 1'b1;
    end else begin
      c.spd_fwd = 16'(v); c.spd_turn = 16'(w); c.override = 1'b0;
    end
    return c;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(shape_command(sample_t'(s_axis_tdata_i)));
        void'(pending_q.pop_front());
      end
      if (s_axis_tvalid_i && !(s_axis_tready_o)) begin
        // hold the offered beat
      end else if (pending_q.size() > 0 && !(tx_idle_en && $urandom_range(99) < 22)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_q[0];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    command_t e;
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat %h/%b", $time, m_axis_tdata_o, m_axis_tuser_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata_o[15:0] !== e.spd_fwd) begin
            $display("%0t: speed_forward exp %0d got %0d", $time, e.spd_fwd,
                     $signed(m_axis_tdata_o[15:0]));
            errors++;
          end
          if (m_axis_tdata_o[31:16] !== e.spd_turn) begin
            $display("%0t: speed_turn exp %0d got %0d", $time, e.spd_turn,
                     $signed(m_axis_tdata_o[31:16]));
            errors++;
          end
          if (m_axis_tuser_o[0] !== e.limited) begin
            $display("%0t: was_limited exp %b got %b", $time, e.limited, m_axis_tuser_o[0]);
            errors++;
          end
          if (m_axis_tuser_o[1] !== e.override) begin
            $display("%0t: straight_override exp %b got %b", $time, e.override,
                     m_axis_tuser_o[1]);
            errors++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(rx_idle_en && $urandom_range(99) < 22);
      end
    end
    if (cycle > MAX_CYCLE) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[MAG_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FWD_MAX:  fwd_max_q  = val & 16'h7fff;
      CFG_TURN_MAX: turn_max_q = val & 16'h7fff;
      CFG_FWD_DZ:   fwd_dz_q   = val & 16'h7fff;
      CFG_TURN_DZ:  turn_dz_q  = val & 16'h7fff;
      CFG_STR_DZ:   str_dz_q   = val & 16'h7fff;
      default:      rev_q      = val & 7;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned fm, int unsigned tm, int unsigned fd,
                            int unsigned td, int unsigned sd, int unsigned rm);
    write_reg(CFG_FWD_MAX, fm);
    write_reg(CFG_TURN_MAX, tm);
    write_reg(CFG_FWD_DZ, fd);
    write_reg(CFG_TURN_DZ, td);
    write_reg(CFG_STR_DZ, sd);
    write_reg(CFG_REV_MASK, rm);
  endtask

  // mostly straight idle so the pair reaches the diamond, full range otherwise
  function automatic logic [15:0] rand_axis(bit allow_zero_bias);
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h8001;
      3: return allow_zero_bias ? 16'h0000 : 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.fwd = rand_axis(1'b0);
    s.turn = rand_axis(1'b0);
    s.straight = ($urandom_range(2) == 0) ? rand_axis(1'b0) : 16'($signed(
      $urandom_range(600)) - 300);
    return s;
  endfunction

  task automatic random_phase(int n);
    repeat (n) pending_q.push_back(rand_sample());
    wait_drained();
  endtask

  initial begin
    fwd_max_q = 32767; turn_max_q = 6553; fwd_dz_q = 983; turn_dz_q = 983;
    str_dz_q = 1311; rev_q = 7;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, dead zone edges, diamond corners, override
    pending_q.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
    pending_q.push_back('{16'sh0000, 16'sh7fff, 16'sh7fff});
    pending_q.push_back('{16'sh0000, -16'sh8000, -16'sh8000});
    pending_q.push_back('{16'sh0000, 16'sh7fff, -16'sh8000});
    pending_q.push_back('{16'sh0000, 16'sh0000, 16'sh7fff});
    pending_q.push_back('{16'sh0000, 16'sh7fff, 16'sh0000});
    pending_q.push_back('{16'sh0000, 16'sd983, 16'sd982});
    pending_q.push_back('{16'sh0000, -16'sd984, -16'sd983});
    pending_q.push_back('{16'sd1311, 16'sh7fff, 16'sh7fff});
    pending_q.push_back('{-16'sh8000, 16'sh0000, 16'sh0000});
    pending_q.push_back('{16'sd1310, 16'sh4000, 16'sh4000});
    pending_q.push_back('{16'shffff, 16'shffff, 16'shffff});
    wait_drained();

    // dead zones just below full scale, zero turn max, no negation
    set_config(32767, 0, 32766, 32766, 32766, 0);
    pending_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_q.push_back('{16'sh8000, 16'sh8001, 16'sh8000});
    pending_q.push_back('{16'sh0000, 16'sh7ffe, 16'sh7ffe});
    wait_drained();
    set_config(0, 32767, 0, 0, 32767, 5);
    pending_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_q.push_back('{16'sh0000, 16'sh0001, 16'sh0001});
    pending_q.push_back('{16'sh0000, 16'sh8000, 16'sh8000});
    wait_drained();
    set_config(32767, 32767, 0, 0, 0, 2);
    pending_q.push_back('{16'sh0000, 16'sh4000, 16'sh4000});
    pending_q.push_back('{16'sh0000, 16'sh0001, 16'shffff});
    wait_drained();

    // random with defaults, then hold the receiver off while feeding
    set_config(32767, 6553, 983, 983, 1311, 7);
    random_phase(150);
    rx_hold = 300;
    tx_idle_en = 1'b0;
    random_phase(100);
    tx_idle_en = 1'b1;

    // no idling on either side
    rx_idle_en = 1'b0; tx_idle_en = 1'b0;
    set_config(20000, 12000, 100, 5000, 0, 1);
    random_phase(150);
    rx_idle_en = 1'b1; tx_idle_en = 1'b1;

    repeat (4) begin
      set_config($urandom_range(32767), $urandom_range(32767), $urandom_range(32766),
                 $urandom_range(32766), $urandom_range(32766), $urandom_range(7));
      random_phase(100);
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

### filelist.f
rtl/core/jvs_pkg.sv
rtl/core/jvs_cfg_regs.sv
rtl/core/jvs_div_pipe.sv
rtl/core/joystick_velocity_shaping.sv
sim/tb_top.sv
